// ===== hdl/rffp_pkg.sv =====
// shared types, constants and helpers for the ranging final frame parser
`default_nettype none
package rffp_pkg;

  localparam int unsigned MAX_ENTRIES    = 8;
  localparam int unsigned POLL_TX_OFS    = 4;
  localparam int unsigned FINAL_TX_OFS   = 9;
  localparam int unsigned COUNT_OFS      = 14;
  localparam int unsigned RESPONDERS_OFS = 15;
  localparam int unsigned ENTRY_LEN      = 6;
  localparam logic [8:0]  POS_MAX        = 9'h1FF;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_HEADER_SHORT = 3'd1,
    ST_COUNT_LARGE  = 3'd2,
    ST_BODY_SHORT   = 3'd3,
    ST_ZERO_FIELD   = 3'd4
  } status_t;

  typedef enum logic {
    KIND_ENTRY   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_payload;
  } in_item_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [31:0] frame_number;
    logic [39:0] poll_send_time;
    logic [39:0] final_send_time;
    logic [7:0]  responder_total;
    logic [2:0]  entry_position;
    logic [7:0]  responder_number;
    logic [39:0] response_receive_time;
    status_t     parse_status;
    logic        last_result;
  } result_t;

  // up to two results leave the parser for one byte
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // replace byte idx of a little-endian 40-bit word
  function automatic logic [39:0] put_byte(input logic [39:0] acc, input logic [2:0] idx,
                                           input logic [7:0] b);
    logic [39:0] r;
    r = acc;
    for (int i = 0; i < 5; i++) begin
      if (idx == 3'(i)) begin
        r[8*i +: 8] = b;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rffp_in_if.sv =====
// byte input channel
`default_nettype none
interface rffp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_payload;

  modport source (output valid, output data_byte, output end_of_payload, input ready);
  modport sink (input valid, input data_byte, input end_of_payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/rffp_out_if.sv =====
// result output channel
`default_nettype none
interface rffp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] frame_number;
  logic [39:0] poll_send_time;
  logic [39:0] final_send_time;
  logic [7:0]  responder_total;
  logic [2:0]  entry_position;
  logic [7:0]  responder_number;
  logic [39:0] response_receive_time;
  logic [2:0]  parse_status;
  logic        last_result;

  modport source (output valid, output result_kind, output frame_number,
                  output poll_send_time, output final_send_time, output responder_total,
                  output entry_position, output responder_number,
                  output response_receive_time, output parse_status, output last_result,
                  input ready);
  modport sink (input valid, input result_kind, input frame_number,
                input poll_send_time, input final_send_time, input responder_total,
                input entry_position, input responder_number,
                input response_receive_time, input parse_status, input last_result,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/rffp_cfg_if.sv =====
// configuration write channel for the payload offset register
`default_nettype none
interface rffp_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] payload_offset;

  modport source (output valid, output payload_offset, input ready);
  modport sink (input valid, input payload_offset, output ready);
endinterface
`default_nettype wire

// ===== hdl/rffp_in_stage.sv =====
// input register stage holding one byte for the parser
`default_nettype none
module rffp_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rffp_in_if.sink                in_ch,
  output rffp_pkg::in_item_t     item,
  output logic                   item_valid,
  input  wire logic              item_take
);

  logic               valid_r;
  rffp_pkg::in_item_t item_r;

  assign in_ch.ready = !valid_r || item_take;
  assign item        = item_r;
  assign item_valid  = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.data_byte      <= in_ch.data_byte;
      item_r.end_of_payload <= in_ch.end_of_payload;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rffp_parser.sv =====
// field gatherer: updates parse state per byte and forms entry and summary results
`default_nettype none
module rffp_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rffp_cfg_if.sink               cfg_ch,
  input  wire rffp_pkg::in_item_t item,
  input  wire logic              item_valid,
  output logic                   item_take,
  input  wire logic              fifo_room,
  output rffp_pkg::push_t        push
);

  logic [6:0]  offset_r;
  logic [8:0]  pos_r, pos_nxt;
  logic [31:0] frame_r, frame_nxt;
  logic [39:0] poll_r, poll_nxt;
  logic [39:0] final_r, final_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [39:0] time_r, time_nxt;
  logic [2:0]  ebc_r, ebc_nxt;
  logic [3:0]  ecnt_r, ecnt_nxt;
  logic        zero_r, zero_nxt;

  logic [8:0]  off9, rel, rel_sub;
  logic        in_msg, entry_emit;
  logic [39:0] frame_tmp;
  logic [7:0]  d;
  rffp_pkg::status_t st;
  rffp_pkg::result_t entry_res, sum_res;

  assign cfg_ch.ready = 1'b1;
  assign item_take    = item_valid && fifo_room;
  assign d            = item.data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_ch.valid) begin
      offset_r <= cfg_ch.payload_offset;
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    frame_nxt  = frame_r;
    poll_nxt   = poll_r;
    final_nxt  = final_r;
    count_nxt  = count_r;
    id_nxt     = id_r;
    time_nxt   = time_r;
    ebc_nxt    = ebc_r;
    ecnt_nxt   = ecnt_r;
    zero_nxt   = zero_r;
    entry_emit = 1'b0;
    frame_tmp  = '0;
    rel_sub    = '0;

    off9   = {2'b00, offset_r};
    in_msg = pos_r >= off9;
    rel    = pos_r - off9;

    if (in_msg) begin
      if (rel < 9'(rffp_pkg::POLL_TX_OFS)) begin
        frame_tmp = rffp_pkg::put_byte({8'd0, frame_r}, rel[2:0], d);
        frame_nxt = frame_tmp[31:0];
      end else if (rel < 9'(rffp_pkg::FINAL_TX_OFS)) begin
        rel_sub  = rel - 9'(rffp_pkg::POLL_TX_OFS);
        poll_nxt = rffp_pkg::put_byte(poll_r, rel_sub[2:0], d);
      end else if (rel < 9'(rffp_pkg::COUNT_OFS)) begin
        rel_sub   = rel - 9'(rffp_pkg::FINAL_TX_OFS);
        final_nxt = rffp_pkg::put_byte(final_r, rel_sub[2:0], d);
      end else if (rel == 9'(rffp_pkg::COUNT_OFS)) begin
        count_nxt = d;
      end else if (count_r <= 8'(rffp_pkg::MAX_ENTRIES) && {4'd0, ecnt_r} < count_r) begin
        if (ebc_r == 3'd0) begin
          id_nxt   = d;
          time_nxt = '0;
        end else begin
          time_nxt = rffp_pkg::put_byte(time_r, ebc_r - 3'd1, d);
        end
        if (ebc_r >= 3'(rffp_pkg::ENTRY_LEN - 1)) begin
          if (id_nxt == 8'd0 || time_nxt == 40'd0) begin
            zero_nxt = 1'b1;
          end
          entry_emit = 1'b1;
          ecnt_nxt   = ecnt_r + 4'd1;
          ebc_nxt    = 3'd0;
        end else begin
          ebc_nxt = ebc_r + 3'd1;
        end
      end
    end

    if (pos_r != rffp_pkg::POS_MAX) begin
      pos_nxt = pos_r + 9'd1;
    end

    // status priority follows the header, count, body, zero-field order
    if ({1'b0, pos_nxt} < ({3'd0, offset_r} + 10'(rffp_pkg::RESPONDERS_OFS))) begin
      st = rffp_pkg::ST_HEADER_SHORT;
    end else if (count_nxt > 8'(rffp_pkg::MAX_ENTRIES)) begin
      st = rffp_pkg::ST_COUNT_LARGE;
    end else if ({4'd0, ecnt_nxt} < count_nxt) begin
      st = rffp_pkg::ST_BODY_SHORT;
    end else if (zero_nxt || poll_nxt == 40'd0 || final_nxt == 40'd0) begin
      st = rffp_pkg::ST_ZERO_FIELD;
    end else begin
      st = rffp_pkg::ST_OK;
    end

    entry_res.result_kind           = rffp_pkg::KIND_ENTRY;
    entry_res.frame_number          = frame_nxt;
    entry_res.poll_send_time        = '0;
    entry_res.final_send_time       = '0;
    entry_res.responder_total       = count_nxt;
    entry_res.entry_position        = ecnt_r[2:0];
    entry_res.responder_number      = id_nxt;
    entry_res.response_receive_time = time_nxt;
    entry_res.parse_status          = rffp_pkg::ST_OK;
    entry_res.last_result           = 1'b0;

    sum_res.result_kind           = rffp_pkg::KIND_SUMMARY;
    sum_res.frame_number          = frame_nxt;
    sum_res.poll_send_time        = poll_nxt;
    sum_res.final_send_time       = final_nxt;
    sum_res.responder_total       = count_nxt;
    sum_res.entry_position        = '0;
    sum_res.responder_number      = '0;
    sum_res.response_receive_time = '0;
    sum_res.parse_status          = st;
    sum_res.last_result           = 1'b1;

    push.count  = item_take ? ({1'b0, entry_emit} + {1'b0, item.end_of_payload}) : 2'd0;
    push.first  = entry_emit ? entry_res : sum_res;
    push.second = sum_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (item_take && item.end_of_payload)) begin
      // end of payload returns the parse state to its reset values
      pos_r   <= '0;
      frame_r <= '0;
      poll_r  <= '0;
      final_r <= '0;
      count_r <= '0;
      id_r    <= '0;
      time_r  <= '0;
      ebc_r   <= '0;
      ecnt_r  <= '0;
      zero_r  <= 1'b0;
    end else if (item_take) begin
      pos_r   <= pos_nxt;
      frame_r <= frame_nxt;
      poll_r  <= poll_nxt;
      final_r <= final_nxt;
      count_r <= count_nxt;
      id_r    <= id_nxt;
      time_r  <= time_nxt;
      ebc_r   <= ebc_nxt;
      ecnt_r  <= ecnt_nxt;
      zero_r  <= zero_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rffp_out_fifo.sv =====
// result queue: takes up to two results per cycle, hands out one per transfer
`default_nettype none
module rffp_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rffp_pkg::push_t   push,
  output logic                   room,
  rffp_out_if.source             out_ch
);

  localparam int unsigned AW = rffp_pkg::FIFO_AW;

  rffp_pkg::result_t mem [rffp_pkg::FIFO_DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              pop;
  rffp_pkg::result_t rd;

  assign pop  = out_ch.valid && out_ch.ready;
  assign room = cnt_r <= (AW+1)'(rffp_pkg::FIFO_DEPTH - 2);
  assign rd   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push.count);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    cnt_nxt    = cnt_r + (AW+1)'(push.count) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_r + AW'(1)] <= push.second;
    end
  end

  assign out_ch.valid                 = cnt_r != '0;
  assign out_ch.result_kind           = rd.result_kind;
  assign out_ch.frame_number          = rd.frame_number;
  assign out_ch.poll_send_time        = rd.poll_send_time;
  assign out_ch.final_send_time       = rd.final_send_time;
  assign out_ch.responder_total       = rd.responder_total;
  assign out_ch.entry_position        = rd.entry_position;
  assign out_ch.responder_number      = rd.responder_number;
  assign out_ch.response_receive_time = rd.response_receive_time;
  assign out_ch.parse_status          = rd.parse_status;
  assign out_ch.last_result           = rd.last_result;

endmodule
`default_nettype wire

// ===== hdl/ranging_final_frame_parser.sv =====
// bytes are registered in the input stage, results in the four-entry result queue
// throughput: one byte per cycle while the queue has room; a byte closing an entry
//   and the payload puts two results in the queue, which drains one per cycle while
//   out is ready; reset (synchronous, rst_n low): payload offset returns to 0, parse
//   state and queue clear; parse state also clears after every end-of-payload byte
`default_nettype none
module ranging_final_frame_parser (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rffp_in_if.sink    in_ch,
  rffp_out_if.source out_ch,
  rffp_cfg_if.sink   cfg_ch
);

  rffp_pkg::in_item_t item;
  logic               item_valid;
  logic               item_take;
  logic               fifo_room;
  rffp_pkg::push_t    push;

  rffp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  rffp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .fifo_room  (fifo_room),
    .push       (push)
  );

  rffp_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (fifo_room),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
